// ----- src/ebws_pkg.sv -----
// ----------------------------------------------------------------------------
// ebws_pkg: shared types and constants for the embedding-bag weighted sum
// Field widths, queue item and configuration types, register indexes.
// ----------------------------------------------------------------------------
package ebws_pkg;

  // Payload field widths
  localparam int ROW_IDX_W  = 10;
  localparam int COL_IDX_W  = 4;
  localparam int ELEM_W     = 16;
  localparam int OUT_W      = 32;
  localparam int POS_W      = 4;

  // Accumulator lanes and width
  localparam int LANES      = 16;
  localparam int LANE_W     = 4;
  localparam int ACC_W      = 40;
  localparam int PROD_W     = 32;

  // Configuration registers
  localparam int BAG_LEN_W  = 8;
  localparam int ROW_WID_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Input item kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COMBINE_MODE = 2'd0,
    REG_BAG_LENGTH   = 2'd1,
    REG_ROW_WIDTH    = 2'd2
  } reg_idx_t;

  // Work classes handed from front to back
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,  // table element write, in range
    OP_LOOKUP = 2'd1,  // lookup of an existing row
    OP_COUNT  = 2'd2   // lookup beyond the table: counts only
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [ROW_IDX_W-1:0]    row_index;
    logic [COL_IDX_W-1:0]    column_index;
    logic signed [ELEM_W-1:0] data;       // table value or lookup weight
  } q_item_t;

  typedef struct packed {
    logic                 combine_mode;
    logic [BAG_LEN_W-1:0] bag_length;
    logic [ROW_WID_W-1:0] row_width;
  } cfg_t;

endpackage

// ----- src/ebws_in_if.sv -----
// ----------------------------------------------------------------------------
// ebws_in_if: input item channel
// Valid/ready channel carrying one table write or one bag lookup.
// ----------------------------------------------------------------------------
interface ebws_in_if;
  import ebws_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [ROW_IDX_W-1:0]      row_index;
  logic [COL_IDX_W-1:0]      column_index;
  logic signed [ELEM_W-1:0]  table_value;
  logic signed [ELEM_W-1:0]  lookup_weight;

  modport source (
    output valid, kind, row_index, column_index, table_value, lookup_weight,
    input  ready
  );

  modport sink (
    input  valid, kind, row_index, column_index, table_value, lookup_weight,
    output ready
  );

endinterface

// ----- src/ebws_out_if.sv -----
// ----------------------------------------------------------------------------
// ebws_out_if: result channel
// Valid/ready channel carrying one combined bag element per transfer.
// ----------------------------------------------------------------------------
interface ebws_out_if;
  import ebws_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  out_value;
  logic [POS_W-1:0]         out_position;
  logic                     out_last;

  modport source (
    output valid, out_value, out_position, out_last,
    input  ready
  );

  modport sink (
    input  valid, out_value, out_position, out_last,
    output ready
  );

endinterface

// ----- src/ebws_cfg_if.sv -----
// ----------------------------------------------------------------------------
// ebws_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ebws_cfg_if;
  import ebws_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );

endinterface

// ----- src/ebws_ram.sv -----
// ----------------------------------------------------------------------------
// ebws_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ebws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/ebws_front.sv -----
// ----------------------------------------------------------------------------
// ebws_front: input classification and work queue
// Sorts each input transfer into write, lookup or count-only work, drops
// out-of-range writes and holds up to two items for the back end.
// ----------------------------------------------------------------------------
module ebws_front #(
  parameter int TABLE_ROWS   = 1024,
  parameter int ROW_ELEMENTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  ebws_in_if.sink           in_chan,
  output ebws_pkg::q_item_t q_item,
  output logic              q_valid,
  input  logic              q_ready
);
  import ebws_pkg::*;

  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  q_item_t           queue_r [QUEUE_DEPTH];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  q_item_t item_c;
  logic    keep_c;
  logic    row_ok, col_ok;
  logic    push, pop;

  // Classify the incoming item
  always_comb begin
    row_ok = 32'(in_chan.row_index) < TABLE_ROWS;
    col_ok = 32'(in_chan.column_index) < ROW_ELEMENTS;
    item_c.row_index    = in_chan.row_index;
    item_c.column_index = in_chan.column_index;
    if (in_chan.kind == KIND_LOOKUP) begin
      item_c.op   = row_ok ? OP_LOOKUP : OP_COUNT;
      item_c.data = in_chan.lookup_weight;
      keep_c      = 1'b1;
    end else begin
      item_c.op   = OP_WRITE;
      item_c.data = in_chan.table_value;
      keep_c      = row_ok && col_ok;
    end
  end

  assign in_chan.ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push          = in_chan.valid && in_chan.ready && keep_c;
  assign q_valid       = (count_r != '0);
  assign pop           = q_valid && q_ready;
  assign q_item        = queue_r[rd_ptr_r];

  // Queue pointers
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= item_c;
    end
  end

endmodule

// ----- src/ebws_back.sv -----
// ----------------------------------------------------------------------------
// ebws_back: table access, accumulation and bag result sequencer
// Writes table elements, walks a looked-up row through the table RAM and a
// registered multiplier into the lane accumulators, and on bag completion
// divides (mean mode), saturates and emits each lane.
// ----------------------------------------------------------------------------
module ebws_back #(
  parameter int TABLE_ROWS   = 1024,
  parameter int ROW_ELEMENTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ebws_pkg::cfg_t    cfg,
  input  ebws_pkg::q_item_t q_item,
  input  logic              q_valid,
  output logic              q_ready,
  ebws_out_if.source        out_chan
);
  import ebws_pkg::*;

  localparam int DEPTH = TABLE_ROWS * ROW_ELEMENTS;
  localparam int TAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP   = (ROW_ELEMENTS < LANES) ? ROW_ELEMENTS : LANES;
  localparam int BIT_W = $clog2(ACC_W);

  localparam logic signed [ACC_W:0] SAT_HI = 41'sd2147483647;
  localparam logic signed [ACC_W:0] SAT_LO = -41'sd2147483648;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_DRAIN = 6'b000100,
    S_LOAD  = 6'b001000,
    S_DIV   = 6'b010000,
    S_SAT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Lookup walk
  logic [TAW-1:0]           base_r, base_nxt;
  logic signed [ELEM_W-1:0] weight_r, weight_nxt;
  logic [LANE_W-1:0]        elem_r, elem_nxt;

  // Read / multiply pipeline
  logic                     rd_v_r, prod_v_r;
  logic [LANE_W-1:0]        idx1_r, idx2_r;
  logic signed [PROD_W-1:0] prod_r;

  // Bag state
  logic [BAG_LEN_W-1:0]     cnt_r, cnt_nxt;
  logic [ACC_W-1:0]         acc_r [LANES];
  logic [ACC_W-1:0]         acc_nxt [LANES];

  // Divide / saturate
  logic [ACC_W-1:0]         mag_r, mag_nxt;
  logic                     neg_r, neg_nxt;
  logic [BAG_LEN_W-1:0]     rem_r, rem_nxt;
  logic [BIT_W-1:0]         bit_r, bit_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0]  out_value_r, out_value_nxt;
  logic [POS_W-1:0]         out_pos_r, out_pos_nxt;
  logic                     out_last_r, out_last_nxt;

  // Table RAM port
  logic                     ram_we, ram_re;
  logic [TAW-1:0]           ram_waddr, ram_raddr, q_base;
  logic [ELEM_W-1:0]        ram_rdata;

  // Derived values
  logic [ROW_WID_W-1:0]     width_eff;
  logic [BAG_LEN_W-1:0]     len_eff;
  logic                     elem_last;
  logic [LANE_W-1:0]        rd_idx;
  logic [ACC_W-1:0]         acc_rd;
  logic [ACC_W-1:0]         prod_ext;
  logic [BAG_LEN_W:0]       rem_sh, rem_diff;
  logic                     q_bit;
  logic signed [ACC_W:0]    res;
  logic [BAG_LEN_W-1:0]     cnt_inc;
  logic                     bag_step, bag_done;

  ebws_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_item.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Effective width and bag length
  always_comb begin
    if (cfg.row_width == '0) begin
      width_eff = ROW_WID_W'(1);
    end else if (cfg.row_width > ROW_WID_W'(CAP)) begin
      width_eff = ROW_WID_W'(CAP);
    end else begin
      width_eff = cfg.row_width;
    end
    len_eff = (cfg.bag_length == '0) ? BAG_LEN_W'(1) : cfg.bag_length;
  end

  assign elem_last = ({1'b0, elem_r} == (width_eff - ROW_WID_W'(1)));

  // Table addressing
  assign q_base    = TAW'(32'(q_item.row_index) * ROW_ELEMENTS);
  assign ram_waddr = q_base + TAW'(q_item.column_index);
  assign ram_raddr = base_r + TAW'(elem_r);

  // Single accumulator read port, shared by accumulate and emit
  assign rd_idx   = (state_r == S_LOAD) ? elem_r : idx2_r;
  assign acc_rd   = acc_r[rd_idx];
  assign prod_ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // One restoring divide step
  assign rem_sh   = {rem_r, mag_r[ACC_W-1]};
  assign rem_diff = rem_sh - {1'b0, len_eff};
  assign q_bit    = (rem_sh >= {1'b0, len_eff});

  // Signed result and bag count
  assign res      = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
  assign cnt_inc  = cnt_r + BAG_LEN_W'(1);
  assign bag_done = (cnt_inc == '0) || (cnt_inc >= len_eff);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    weight_nxt    = weight_r;
    elem_nxt      = elem_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_value_nxt = out_value_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    q_ready       = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    bag_step      = 1'b0;

    // accumulate a product that left the multiplier
    if (prod_v_r) begin
      acc_nxt[idx2_r] = acc_rd + prod_ext;
    end

    unique case (state_r)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          unique case (q_item.op)
            OP_WRITE: begin
              ram_we = 1'b1;
            end
            OP_LOOKUP: begin
              base_nxt   = q_base;
              weight_nxt = q_item.data;
              elem_nxt   = '0;
              state_nxt  = S_LOOK;
            end
            OP_COUNT: begin
              bag_step = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_LOOK: begin
        ram_re = 1'b1;
        if (elem_last) begin
          state_nxt = S_DRAIN;
        end else begin
          elem_nxt = elem_r + LANE_W'(1);
        end
      end
      S_DRAIN: begin
        if (!rd_v_r && !prod_v_r) begin
          bag_step = 1'b1;
        end
      end
      S_LOAD: begin
        neg_nxt   = acc_rd[ACC_W-1];
        mag_nxt   = acc_rd[ACC_W-1] ? -acc_rd : acc_rd;
        rem_nxt   = '0;
        bit_nxt   = '0;
        state_nxt = cfg.combine_mode ? S_DIV : S_SAT;
      end
      S_DIV: begin
        mag_nxt = {mag_r[ACC_W-2:0], q_bit};
        rem_nxt = q_bit ? rem_diff[BAG_LEN_W-1:0] : rem_sh[BAG_LEN_W-1:0];
        bit_nxt = bit_r + BIT_W'(1);
        if (bit_r == BIT_W'(ACC_W - 1)) begin
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          if (res > SAT_HI) begin
            out_value_nxt = SAT_HI[OUT_W-1:0];
          end else if (res < SAT_LO) begin
            out_value_nxt = SAT_LO[OUT_W-1:0];
          end else begin
            out_value_nxt = res[OUT_W-1:0];
          end
          out_pos_nxt  = POS_W'(elem_r);
          out_last_nxt = elem_last;
          if (elem_last) begin
            for (int i = 0; i < LANES; i++) begin
              acc_nxt[i] = '0;
            end
            state_nxt = S_IDLE;
          end else begin
            elem_nxt  = elem_r + LANE_W'(1);
            state_nxt = S_LOAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // lookup counted: finish the bag or go back for more
    if (bag_step) begin
      if (bag_done) begin
        cnt_nxt   = '0;
        elem_nxt  = '0;
        state_nxt = S_LOAD;
      end else begin
        cnt_nxt   = cnt_inc;
        state_nxt = S_IDLE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= ram_re;
      prod_v_r    <= rd_v_r;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    weight_r    <= weight_nxt;
    elem_r      <= elem_nxt;
    idx1_r      <= elem_r;
    idx2_r      <= idx1_r;
    prod_r      <= $signed(ram_rdata) * weight_r;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    rem_r       <= rem_nxt;
    bit_r       <= bit_nxt;
    out_value_r <= out_value_nxt;
    out_pos_r   <= out_pos_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.out_value    = out_value_r;
  assign out_chan.out_position = out_pos_r;
  assign out_chan.out_last     = out_last_r;

endmodule

// ----- src/embedding_bag_weighted_sum.sv -----
// ----------------------------------------------------------------------------
// embedding_bag_weighted_sum: forward embedding-bag combiner, sum or mean
// Top level: configuration registers, front classifier/queue, back end.
// ----------------------------------------------------------------------------
// Items go into a two-entry queue, so the input keeps taking transfers while
// the back end works, until the queue is full. A table write is done as it
// leaves the queue. For a lookup, the row's W elements (W = effective row
// width, 1 .. 16) are read one per cycle through the single read port of the
// table RAM and drain through the read register, the multiply register and
// the accumulators. When a bag completes, each of the W results passes
// S_LOAD and S_SAT in sum mode, plus S_DIV in mean mode, where the bit-serial
// divider works through the 40-bit accumulator one bit per cycle; no item is
// taken from the queue meanwhile. Results leave through an output register.
// The table RAM has no reset value and no clearing pass; it reads garbage
// until written. Configuration must be written only when idle (unchecked).
// ----------------------------------------------------------------------------
module embedding_bag_weighted_sum #(
  parameter int TABLE_ROWS   = 1024,
  parameter int ROW_ELEMENTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ebws_in_if.sink     in_chan,
  ebws_out_if.source  out_chan,
  ebws_cfg_if.sink    cfg_chan
);
  import ebws_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  q_item_t q_item;
  logic    q_valid, q_ready;

  // Configuration registers
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_COMBINE_MODE: cfg_nxt.combine_mode = cfg_chan.data[0];
        REG_BAG_LENGTH:   cfg_nxt.bag_length   = cfg_chan.data[BAG_LEN_W-1:0];
        REG_ROW_WIDTH:    cfg_nxt.row_width    = cfg_chan.data[ROW_WID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.combine_mode <= 1'b0;
      cfg_r.bag_length   <= BAG_LEN_W'(1);
      cfg_r.row_width    <= ROW_WID_W'(16);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ebws_front #(
    .TABLE_ROWS   (TABLE_ROWS),
    .ROW_ELEMENTS (ROW_ELEMENTS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  ebws_back #(
    .TABLE_ROWS   (TABLE_ROWS),
    .ROW_ELEMENTS (ROW_ELEMENTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .out_chan (out_chan)
  );

endmodule
